/* src/rpc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpc_pkg: region permission check shared definitions
// Word format for the cell chain, opcodes, access kinds, register map.
// ----------------------------------------------------------------------------
package rpc_pkg;

    localparam int NUM_REGIONS_DEF = 16;
    localparam int ADDR_WIDTH_DEF  = 64;

    // fixed field widths
    localparam int FIELD_ADDR_W = 64;
    localparam int IDX_W        = 4;
    localparam int KIND_W       = 2;
    localparam int CNT_W        = 5;
    // wide enough to hold any cell number (up to 256) and the region count
    localparam int CMP_W        = 9;

    // stream packing
    localparam int S_TDATA_W = 200;
    localparam int M_TDATA_W = 8;

    // APB
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic REG_REGIONS_IN_USE = 1'b0;

    typedef enum logic [KIND_W-1:0] {
        ACC_READ  = 2'd0,
        ACC_WRITE = 2'd1,
        ACC_RW    = 2'd2
    } access_kind_t;

    // one word moving down the chain; a load uses addr_a/addr_b as bounds,
    // a query uses addr_a as the address and carries the running hit
    typedef struct packed {
        logic                    valid;
        logic                    op;
        logic [IDX_W-1:0]        idx;
        logic [FIELD_ADDR_W-1:0] addr_a;
        logic [FIELD_ADDR_W-1:0] addr_b;
        logic                    rd;
        logic                    wr;
        logic [KIND_W-1:0]       kind;
        logic                    hit;
    } rpc_word_t;

endpackage
`default_nettype wire

/* src/rpc_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpc_cell: one region slot of the check chain
// Holds one region entry, captures loads aimed at it, folds its verdict
// into passing queries, and registers the word for the next cell.
// ----------------------------------------------------------------------------
module rpc_cell #(
    parameter int CELL_IDX   = 0,
    parameter int ADDR_WIDTH = rpc_pkg::ADDR_WIDTH_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      advance,
    input  wire logic [rpc_pkg::CNT_W-1:0] regions_in_use,
    input  wire rpc_pkg::rpc_word_t        word_in,
    output      rpc_pkg::rpc_word_t        word_out
);

    localparam logic [rpc_pkg::CMP_W-1:0] CELL_ID = rpc_pkg::CMP_W'(CELL_IDX);

    logic [ADDR_WIDTH-1:0] start_reg;
    logic [ADDR_WIDTH-1:0] end_reg;
    logic                  rd_reg;
    logic                  wr_reg;

    logic                  valid_reg;
    rpc_pkg::rpc_word_t    data_reg;
    rpc_pkg::rpc_word_t    data_next;

    logic                  in_use;
    logic                  slot_hit;
    logic                  load_here;
    logic                  perm;
    logic                  in_range;
    logic [ADDR_WIDTH-1:0] addr;

    assign in_use    = CELL_ID < rpc_pkg::CMP_W'(regions_in_use);
    assign slot_hit  = rpc_pkg::CMP_W'(word_in.idx) == CELL_ID;
    assign load_here = advance && word_in.valid && (word_in.op == rpc_pkg::OP_LOAD)
                       && slot_hit;
    assign addr      = word_in.addr_a[ADDR_WIDTH-1:0];
    assign in_range  = (addr >= start_reg) && (addr <= end_reg);

    always_comb
    begin
        case (word_in.kind)
            rpc_pkg::ACC_READ:  perm = rd_reg;
            rpc_pkg::ACC_WRITE: perm = wr_reg;
            rpc_pkg::ACC_RW:    perm = rd_reg && wr_reg;
            default:            perm = 1'b0;
        endcase
    end

    always_comb
    begin
        data_next = word_in;
        if (word_in.op == rpc_pkg::OP_QUERY && in_use && perm && in_range)
        begin
            data_next.hit = 1'b1;
        end
    end

    // entry storage, undefined until loaded
    always_ff @(posedge clk)
    begin
        if (load_here)
        begin
            start_reg <= word_in.addr_a[ADDR_WIDTH-1:0];
            end_reg   <= word_in.addr_b[ADDR_WIDTH-1:0];
            rd_reg    <= word_in.rd;
            wr_reg    <= word_in.wr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= word_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        word_out       = data_reg;
        word_out.valid = valid_reg;
    end

endmodule
`default_nettype wire

/* src/rpc_apb_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpc_apb_regs: configuration register file
// APB slave holding the regions_in_use count; zero wait states.
// ----------------------------------------------------------------------------
module rpc_apb_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [rpc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [rpc_pkg::APB_DATA_W-1:0] pwdata,
    output      logic [rpc_pkg::APB_DATA_W-1:0] prdata,
    output      logic                           pready,
    output      logic [rpc_pkg::CNT_W-1:0]      regions_in_use
);

    logic                      reg_idx;
    logic                      wr_en;
    logic [rpc_pkg::CNT_W-1:0] regions_in_use_reg;

    // word index of the byte address; the low two bits select bytes
    assign reg_idx = paddr[rpc_pkg::APB_ADDR_W-1];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready
                     && (reg_idx == rpc_pkg::REG_REGIONS_IN_USE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regions_in_use_reg <= '0;
        end
        else if (wr_en)
        begin
            regions_in_use_reg <= pwdata[rpc_pkg::CNT_W-1:0];
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            rpc_pkg::REG_REGIONS_IN_USE:
                prdata = rpc_pkg::APB_DATA_W'(regions_in_use_reg);
            default:
                prdata = '0;
        endcase
    end

    assign regions_in_use = regions_in_use_reg;

endmodule
`default_nettype wire

/* src/region_permission_check_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Path: a query word passes through the NUM_REGIONS cell registers, then the output register.
// Throughput: one word per cycle, loads and queries mixed freely, while no blocked result halts the row.
// The chain has NUM_REGIONS cells, one register stage per region slot.
// Reset clears the chain valid bits, the output valid bit and regions_in_use;
// region entries hold no reset value and must be loaded before a query uses them.
// ----------------------------------------------------------------------------
// region_permission_check_core: memory protection region check
// A row of NUM_REGIONS cells, each owning one region slot. Every word walks
// the row one cell per cycle while it advances: a load drops its bounds and
// permissions into the cell whose number matches entry_index, a query collects
// a hit bit from each cell in use. Since loads and queries move at the same
// pace, a query sees exactly the loads accepted before it. Query results land
// in an output register at the end of the row; load words leave the row silently.
// ----------------------------------------------------------------------------
module region_permission_check_core #(
    parameter int NUM_REGIONS = rpc_pkg::NUM_REGIONS_DEF,
    parameter int ADDR_WIDTH  = rpc_pkg::ADDR_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    // input stream
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    // [3:0] entry_index, [67:4] region_start, [131:68] region_end,
    // [132] region_readable, [133] region_writable, [197:134] query_address,
    // [199:198] access_kind
    input  wire logic [rpc_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] operation
    input  wire logic [0:0]                     s_tuser,

    // result stream
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    // [0] granted, [7:1] zero
    output      logic [rpc_pkg::M_TDATA_W-1:0]  m_tdata,

    // configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [rpc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [rpc_pkg::APB_DATA_W-1:0] pwdata,
    output      logic [rpc_pkg::APB_DATA_W-1:0] prdata,
    output      logic                           pready
);

    logic [rpc_pkg::CNT_W-1:0] regions_in_use;

    rpc_pkg::rpc_word_t chain [NUM_REGIONS+1];
    rpc_pkg::rpc_word_t last_word;

    logic advance;
    logic last_query;
    logic out_valid_reg;
    logic out_valid_next;
    logic granted_reg;

    rpc_apb_regs u_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .regions_in_use (regions_in_use)
    );

    // unpack the incoming word; the hit bit starts clear
    always_comb
    begin
        chain[0].valid  = s_tvalid;
        chain[0].op     = s_tuser[0];
        chain[0].idx    = s_tdata[3:0];
        chain[0].addr_a = (s_tuser[0] == rpc_pkg::OP_QUERY) ? s_tdata[197:134]
                                                            : s_tdata[67:4];
        chain[0].addr_b = s_tdata[131:68];
        chain[0].rd     = s_tdata[132];
        chain[0].wr     = s_tdata[133];
        chain[0].kind   = s_tdata[199:198];
        chain[0].hit    = 1'b0;
    end

    // the row of region cells
    for (genvar g = 0; g < NUM_REGIONS; g++)
    begin : g_cell
        rpc_cell #(
            .CELL_IDX   (g),
            .ADDR_WIDTH (ADDR_WIDTH)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .advance        (advance),
            .regions_in_use (regions_in_use),
            .word_in        (chain[g]),
            .word_out       (chain[g+1])
        );
    end

    assign last_word  = chain[NUM_REGIONS];
    assign last_query = last_word.valid && (last_word.op == rpc_pkg::OP_QUERY);

    // The row only halts when a finished query is at its end and the output
    // register still holds an untaken result; otherwise words keep moving.
    assign advance  = !(last_query && out_valid_reg && !m_tready);
    assign s_tready = advance;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && last_query)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_query)
        begin
            granted_reg <= last_word.hit;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = rpc_pkg::M_TDATA_W'(granted_reg);

    // input back-pressure only comes from a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a blocked result");

    // a query leaving the row always lands in the output register
    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && last_query) |=> m_tvalid)
        else $error("query result lost at end of chain");

    // a held result is never dropped while the row is frozen behind it
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> (m_tvalid && $stable(granted_reg)))
        else $error("result changed during stall");

endmodule
`default_nettype wire
